// ===== hw/rtl/ring_buffer_fifo_defines.svh =====
// Assertion macros shared by the ring buffer FIFO modules.
`ifndef RING_BUFFER_FIFO_DEFINES_SVH
`define RING_BUFFER_FIFO_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RBF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define RBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rbf_pkg.sv =====
// Package with the types and constants of the ring buffer FIFO.
`timescale 1ns / 1ps
package rbf_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned OUT_W  = 48;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_FRONT = 3'd2,
    REQ_BACK  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic exec;      // request accepted this cycle
    logic load_out;  // move the finished result into the output register
  } rbf_cmd_t;

  // Capacity in use: zero counts as one, anything above DEPTH as DEPTH.
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] value);
    logic [CNT_W-1:0] res;
    if (value == '0) begin
      res = CNT_W'(1);
    end else if (32'(value) > DEPTH) begin
      res = CNT_W'(DEPTH);
    end else begin
      res = CNT_W'(value);
    end
    return res;
  endfunction

  // Pointer step with wrap at the capacity in use.
  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] nxt;
    nxt = (CNT_W+1)'(p) + (CNT_W+1)'(1);
    return (nxt >= (CNT_W+1)'(cap)) ? '0 : nxt[PTR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/rbf_ctrl.sv =====
// Controller state machine sequencing request execution and result hand-off.
`timescale 1ns / 1ps
module rbf_ctrl
  import rbf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rbf_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.exec     = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // The result waits here until the output register has room.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/rbf_datapath.sv =====
// Datapath: entry memory, pointers, occupancy count and the result register.
`timescale 1ns / 1ps
`include "ring_buffer_fifo_defines.svh"
module rbf_datapath
  import rbf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rbf_cmd_t         cmd_i,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output logic [OUT_W-1:0] result_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CNT_W-1:0] cap_q, cap_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             we;
  logic             hit;
  status_e          stat;
  logic [PTR_W-1:0] raddr;

  logic [DATA_WIDTH-1:0] rd_word_q;
  logic                  hit_q;
  status_e               stat_q;
  logic [CNT_W-1:0]      res_cnt_q;

  logic [WORD_W-1:0] out_rd_q;
  status_e           out_stat_q;
  logic [OCC_W-1:0]  out_occ_q;
  logic              out_full_q;
  logic              out_empty_q;

  always_comb begin
    cap_d  = cap_q;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    we     = 1'b0;
    hit    = 1'b0;
    stat   = STAT_OK;
    raddr  = head_q;
    if (cfg_we_i) begin
      // A new capacity also empties the buffer.
      cap_d  = eff_cap(cfg_data_i);
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
    end else if (cmd_i.exec) begin
      unique case (req_type_i)
        REQ_PUSH: begin
          if (cnt_q >= cap_q) begin
            stat = STAT_FULL;
          end else begin
            we     = 1'b1;
            tail_d = ptr_adv(tail_q, cap_q);
            cnt_d  = cnt_q + CNT_W'(1);
          end
        end
        REQ_POP: begin
          if (cnt_q == '0) begin
            stat = STAT_EMPTY;
          end else begin
            head_d = ptr_adv(head_q, cap_q);
            cnt_d  = cnt_q - CNT_W'(1);
          end
        end
        REQ_FRONT: begin
          if (cnt_q == '0) begin
            stat = STAT_EMPTY;
          end else begin
            hit = 1'b1;
          end
        end
        REQ_BACK: begin
          raddr = (tail_q == '0) ? PTR_W'(cap_q - CNT_W'(1)) : tail_q - PTR_W'(1);
          if (cnt_q == '0) begin
            stat = STAT_EMPTY;
          end else begin
            hit = 1'b1;
          end
        end
        REQ_CLEAR: begin
          head_d = '0;
          tail_d = '0;
          cnt_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CNT_W'(DEPTH);
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      cap_q  <= cap_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Single write port at the tail, registered read at the selected entry.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[tail_q] <= wr_data_i[DATA_WIDTH-1:0];
    end
    if (cmd_i.exec) begin
      rd_word_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      hit_q     <= hit;
      stat_q    <= stat;
      res_cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rd_q    <= hit_q ? WORD_W'(rd_word_q) : '0;
      out_stat_q  <= stat_q;
      out_occ_q   <= OCC_W'(res_cnt_q);
      out_full_q  <= (res_cnt_q == cap_q);
      out_empty_q <= (res_cnt_q == '0);
    end
  end

  assign result_o = {(OUT_W - WORD_W - STAT_W - OCC_W - 2)'(0),
                     out_empty_q, out_full_q, out_occ_q, out_stat_q, out_rd_q};

  `RBF_ASSERT_ALWAYS(a_cnt_in_cap, cnt_q <= cap_q, "occupancy exceeds capacity")
  `RBF_ASSERT_ALWAYS(a_ptr_in_cap, (CNT_W'(head_q) < cap_q) && (CNT_W'(tail_q) < cap_q), "pointer beyond capacity")
  `RBF_ASSERT_NEXT(a_push_counts, cmd_i.exec && !cfg_we_i && (req_type_i == REQ_PUSH) && (cnt_q < cap_q), cnt_q == $past(cnt_q) + CNT_W'(1), "accepted push did not raise occupancy")

endmodule

// ===== hw/rtl/ring_buffer_fifo.sv =====
// Top level of the ring buffer FIFO: controller, datapath and ports.
//
// Requests arrive on the s_axis stream: tuser carries the request kind
// (push, pop, read front, read back, clear) and tdata the word to push.
// Each request produces exactly one result word on the m_axis stream
// with the read word, a status code, the occupancy after the request
// and the full and empty flags.
// A request first updates the pointers and reads the entry memory
// through its registered read port, then moves the result into the
// output register. A new request is taken only once the previous
// result has moved into the output register.
// The user must write the capacity register on the cfg channel only
// while no request is in flight; the block does not enforce it.
// A write also empties the buffer. Reset empties the buffer and sets the
// capacity to the full depth; the stored words are not cleared.
// When the receiver stalls, the result is held in the output register
// and one more request is still taken; the block then waits with it
// until the output register is free.
`timescale 1ns / 1ps
module ring_buffer_fifo
  import rbf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [WORD_W-1:0] s_axis_tdata,  // wr_data
  input  logic [REQ_W-1:0]  s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // rd_data, status, occupancy, full_flag, empty_flag, zero padding
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CAP_W-1:0]  cfg_data_i       // capacity
);

  rbf_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  rbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  rbf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_type_i (s_axis_tuser),
    .wr_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (m_axis_tdata)
  );

endmodule
